// ===== src/cbp_pkg.sv =====
// ----------------------------------------------------------------------------
// cbp_pkg: shared types and constants of the constant border padder
// Geometry limits, register indexes, the clamped geometry bundle and the
// per-item run lengths handed from the position tracker to the emitter.
// ----------------------------------------------------------------------------
package cbp_pkg;

    localparam int MAX_DIM   = 1024;
    localparam int MAX_PAD   = 15;

    localparam int WORD_W    = 32;
    localparam int DIM_W     = 11;
    localparam int PAD_W     = 4;
    localparam int CNT_W     = 14;
    localparam int POS_W     = $clog2(MAX_DIM);
    // plane height: rows + top + bottom, at most 1024 + 30
    localparam int HGT_W     = 11;
    localparam int CFG_IDX_W = 3;

    // stream packing
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_ROWS      = 3'd0,
        CFG_IN_COLS      = 3'd1,
        CFG_NUM_CHANNELS = 3'd2,
        CFG_PAD_TOP      = 3'd3,
        CFG_PAD_BOTTOM   = 3'd4,
        CFG_PAD_LEFT     = 3'd5,
        CFG_PAD_RIGHT    = 3'd6,
        CFG_PAD_VALUE    = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_DATA,
        PH_TRAIL
    } t_phase;

    // clamped geometry
    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
        logic [DIM_W-1:0] chans;
        logic [PAD_W-1:0] pt;
        logic [PAD_W-1:0] pb;
        logic [PAD_W-1:0] pl;
        logic [PAD_W-1:0] pr;
    } t_geom;

    // run lengths of the element at the current position
    typedef struct packed {
        logic [CNT_W-1:0] lead;
        logic [CNT_W-1:0] trail;
        logic             tensor_end;
    } t_runs;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [PAD_W-1:0] clamp_pad(input logic [PAD_W-1:0] v);
        logic [PAD_W+1:0] w;
        logic [PAD_W-1:0] r;
        w = (PAD_W+2)'(v);
        if (w > (PAD_W+2)'(MAX_PAD)) begin
            r = PAD_W'(MAX_PAD);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== src/constant_border_padder.sv =====
// ----------------------------------------------------------------------------
// constant_border_padder: constant border padding of 2-D channel planes
// Passes column-major tensor elements through and inserts runs of a pad word
// so that each plane gains top, bottom, left and right borders.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one 32-bit element per request, channel after channel,
//   columns outer and rows inner. m_axis carries results: a pad run (pad word
//   plus repeat count) or one data word with count 1. An element on row 0
//   gives a leading pad run first, one on the last row a trailing run after, if not empty.
//   Geometry and pad word are written through the cfg port while idle.
// Timing:
//   an accepted element is held in the item register, each result of it is
//   registered in the output register; it causes 1 to 3 results. The single
//   item register takes the next element as the last result leaves, so
//   interior elements stream at one per cycle while m_axis_tready is high.
// Reset:
//   synchronous, active low; clears positions, empties both stages and loads
//   the geometry with 1x1x1 planes, no padding and pad word zero.
// Stall:
//   while m_axis_tready is low the output register holds, the item register
//   fills and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module constant_border_padder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write port
    input  logic                           i_cfg_we,
    input  logic [cbp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cbp_pkg::WORD_W-1:0]     i_cfg_data,
    // element input
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [cbp_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // [31:0] elem_word
    // result output
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [cbp_pkg::M_TDATA_W-1:0]  m_axis_tdata,   // [31:0] out_word,
                                                            // [45:32] repeat_count,
                                                            // [47:46] zero
    output logic [cbp_pkg::M_TUSER_W-1:0]  m_axis_tuser,   // [0] is_pad,
                                                            // [1] last_of_item
    output logic                           m_axis_tlast    // last_of_tensor
);
    import cbp_pkg::*;

    // configuration
    logic [DIM_W-1:0]  r_in_rows, r_in_cols, r_num_channels;
    logic [PAD_W-1:0]  r_pad_top, r_pad_bottom, r_pad_left, r_pad_right;
    logic [WORD_W-1:0] r_pad_value;
    t_geom             w_geom;

    // item stage
    logic              r_a_valid;
    t_phase            r_a_phase;
    logic [WORD_W-1:0] r_a_word;
    t_runs             r_a_runs;

    // output stage
    logic              r_o_valid;
    logic [WORD_W-1:0] r_o_word;
    logic [CNT_W-1:0]  r_o_count;
    logic              r_o_pad, r_o_lit, r_o_lot;

    logic              n_o_pad, n_o_lit, n_o_lot;
    logic [WORD_W-1:0] n_o_word;
    logic [CNT_W-1:0]  n_o_count;
    t_phase            n_a_phase;

    logic              w_emit, w_a_done, w_in_acc;
    t_runs             w_runs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_rows      <= DIM_W'(1);
            r_in_cols      <= DIM_W'(1);
            r_num_channels <= DIM_W'(1);
            r_pad_top      <= '0;
            r_pad_bottom   <= '0;
            r_pad_left     <= '0;
            r_pad_right    <= '0;
            r_pad_value    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_IN_ROWS:      r_in_rows      <= i_cfg_data[DIM_W-1:0];
                CFG_IN_COLS:      r_in_cols      <= i_cfg_data[DIM_W-1:0];
                CFG_NUM_CHANNELS: r_num_channels <= i_cfg_data[DIM_W-1:0];
                CFG_PAD_TOP:      r_pad_top      <= i_cfg_data[PAD_W-1:0];
                CFG_PAD_BOTTOM:   r_pad_bottom   <= i_cfg_data[PAD_W-1:0];
                CFG_PAD_LEFT:     r_pad_left     <= i_cfg_data[PAD_W-1:0];
                CFG_PAD_RIGHT:    r_pad_right    <= i_cfg_data[PAD_W-1:0];
                CFG_PAD_VALUE:    r_pad_value    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_geom.rows  = clamp_dim(r_in_rows);
    assign w_geom.cols  = clamp_dim(r_in_cols);
    assign w_geom.chans = clamp_dim(r_num_channels);
    assign w_geom.pt    = clamp_pad(r_pad_top);
    assign w_geom.pb    = clamp_pad(r_pad_bottom);
    assign w_geom.pl    = clamp_pad(r_pad_left);
    assign w_geom.pr    = clamp_pad(r_pad_right);

    cbp_run_calc u_run_calc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (w_geom),
        .i_advance (w_in_acc),
        .o_runs    (w_runs)
    );

    // pick the next result of the held item
    always_comb begin
        n_o_word  = r_pad_value;
        n_o_count = r_a_runs.lead;
        n_o_pad   = 1'b1;
        n_o_lit   = 1'b0;
        n_o_lot   = 1'b0;
        n_a_phase = PH_DATA;
        w_a_done  = 1'b0;
        case (r_a_phase)
            PH_LEAD: begin
                n_a_phase = PH_DATA;
            end
            PH_DATA: begin
                n_o_word  = r_a_word;
                n_o_count = CNT_W'(1);
                n_o_pad   = 1'b0;
                n_o_lit   = (r_a_runs.trail == '0);
                n_o_lot   = (r_a_runs.trail == '0) && r_a_runs.tensor_end;
                n_a_phase = PH_TRAIL;
                w_a_done  = (r_a_runs.trail == '0);
            end
            PH_TRAIL: begin
                n_o_count = r_a_runs.trail;
                n_o_lit   = 1'b1;
                n_o_lot   = r_a_runs.tensor_end;
                w_a_done  = 1'b1;
            end
            default: begin
                w_a_done  = 1'b1;
            end
        endcase
    end

    assign w_emit        = r_a_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_a_valid || (w_emit && w_a_done);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_phase <= PH_DATA;
        end else if (w_in_acc) begin
            r_a_valid <= 1'b1;
            r_a_phase <= (w_runs.lead != '0) ? PH_LEAD : PH_DATA;
        end else if (w_emit) begin
            if (w_a_done) begin
                r_a_valid <= 1'b0;
            end else begin
                r_a_phase <= n_a_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_word <= s_axis_tdata[WORD_W-1:0];
            r_a_runs <= w_runs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_emit) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_word  <= n_o_word;
            r_o_count <= n_o_count;
            r_o_pad   <= n_o_pad;
            r_o_lit   <= n_o_lit;
            r_o_lot   <= n_o_lot;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {(M_TDATA_W-WORD_W-CNT_W)'(0), r_o_count, r_o_word};
    assign m_axis_tuser  = {r_o_lit, r_o_pad};
    assign m_axis_tlast  = r_o_lot;

    // an accepted element is always held in the item stage in the next cycle
    a_accept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_a_valid)
        else $error("accepted element not held in item stage");

    // runs of zero length never leave the block
    a_no_empty_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_count != '0))
        else $error("zero-length run emitted");

    // a data word always covers exactly one position
    a_data_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_pad) |-> (r_o_count == CNT_W'(1)))
        else $error("data word with repeat count other than one");

    // end of tensor only on the final result of an element
    a_tensor_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_lot) |-> r_o_lit)
        else $error("end of tensor on a non-final result");

    // a leading run is never followed by another leading run of the same item
    a_lead_then_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_a_phase == PH_LEAD) |=> (r_a_valid && r_a_phase == PH_DATA))
        else $error("leading run not followed by its data word");

endmodule

// ===== src/cbp_run_calc.sv =====
// ----------------------------------------------------------------------------
// cbp_run_calc: position tracker and border run lengths
// Keeps row, column and channel of the next element and works out the
// leading and trailing pad runs and the end-of-tensor mark for it.
// ----------------------------------------------------------------------------
module cbp_run_calc (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cbp_pkg::t_geom i_geom,
    input  logic           i_advance,
    output cbp_pkg::t_runs o_runs
);
    import cbp_pkg::*;

    logic [POS_W-1:0] r_row_pos, r_col_pos, r_chan_pos;

    logic             w_first_row, w_first_col;
    logic             w_last_row, w_last_col, w_last_chan;
    logic [HGT_W-1:0] w_height;
    logic [CNT_W-1:0] w_side_l, w_side_r;

    assign w_first_row = (r_row_pos == '0);
    assign w_first_col = (r_col_pos == '0);
    // a position at or beyond the last index counts as the last one
    assign w_last_row  = (DIM_W'(r_row_pos) + DIM_W'(1)) >= i_geom.rows;
    assign w_last_col  = (DIM_W'(r_col_pos) + DIM_W'(1)) >= i_geom.cols;
    assign w_last_chan = (DIM_W'(r_chan_pos) + DIM_W'(1)) >= i_geom.chans;

    assign w_height = HGT_W'(i_geom.rows) + HGT_W'(i_geom.pt) + HGT_W'(i_geom.pb);
    assign w_side_l = CNT_W'(i_geom.pl) * CNT_W'(w_height);
    assign w_side_r = CNT_W'(i_geom.pr) * CNT_W'(w_height);

    always_comb begin
        o_runs.lead  = '0;
        o_runs.trail = '0;
        if (w_first_row) begin
            o_runs.lead = CNT_W'(i_geom.pt) + (w_first_col ? w_side_l : '0);
        end
        if (w_last_row) begin
            o_runs.trail = CNT_W'(i_geom.pb) + (w_last_col ? w_side_r : '0);
        end
        o_runs.tensor_end = w_last_row && w_last_col && w_last_chan;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pos  <= '0;
            r_col_pos  <= '0;
            r_chan_pos <= '0;
        end else if (i_advance) begin
            if (!w_last_row) begin
                r_row_pos <= r_row_pos + POS_W'(1);
            end else begin
                r_row_pos <= '0;
                if (!w_last_col) begin
                    r_col_pos <= r_col_pos + POS_W'(1);
                end else begin
                    r_col_pos <= '0;
                    if (!w_last_chan) begin
                        r_chan_pos <= r_chan_pos + POS_W'(1);
                    end else begin
                        r_chan_pos <= '0;
                    end
                end
            end
        end
    end

endmodule
